### design/dsmi_pkg.sv
// Shared widths, cofactor index tables and the saturation helper for the
// dimension-selectable 3x3 matrix inverse core. No dependencies.
`default_nettype none

package dsmi_pkg;

   localparam int N           = 9;    // elements per tensor
   localparam int EW          = 32;   // element width, signed Q16.16
   localparam int PW          = 64;   // element product width
   localparam int CW          = 65;   // cofactor width
   localparam int DETW        = 98;   // full-precision determinant width
   localparam int MAGW        = 97;   // determinant magnitude width
   localparam int AMW         = 64;   // cofactor magnitude width
   localparam int QW          = 32;   // quotient bits per inverse entry
   localparam int IN_TDATA_W  = 288;
   localparam int OUT_TDATA_W = 328;
   localparam int DET_LSB     = 288;
   localparam int SING_BIT    = 320;

   localparam logic [1:0] DIM_NONE = 2'd0;
   localparam logic [1:0] DIM_ONE  = 2'd1;
   localparam logic [1:0] DIM_TWO  = 2'd2;
   localparam logic [1:0] DIM_FULL = 2'd3;

   localparam logic [EW-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [EW-1:0] SAT_NEG = 32'h8000_0000;

   // Cofactor i is e[A]*e[B] - e[C]*e[D], laid out as the adjugate in row-major order.
   localparam int COF_A [N] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_B [N] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_C [N] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
   localparam int COF_D [N] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};

   typedef logic signed [EW-1:0] elem_type;

   typedef struct packed {
      logic [EW-1:0] value;
      logic          sat;
   } sat_type;

   // Sideband that travels alongside the divider lanes.
   typedef struct packed {
      logic [MAGW-1:0] dmag;
      logic            dzero;
      logic [N-1:0]    act;
      logic [N-1:0]    neg;
      logic [N-1:0]    azero;
      logic [N-1:0]    big;
      logic [EW-1:0]   det_out;
      logic            det_flag;
   } side_type;

   function automatic sat_type sat32(input logic [MAGW-1:0] mag, input logic neg);
      sat_type r;
      if (neg) begin
         r.sat   = mag > MAGW'(SAT_NEG);
         r.value = r.sat ? SAT_NEG : (~mag[EW-1:0] + EW'(1));
      end else begin
         r.sat   = mag > MAGW'(SAT_POS);
         r.value = r.sat ? SAT_POS : mag[EW-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### design/dim_select_matrix_inverse_core.sv
// Top level of the dimension-selectable 3x3 matrix inverse (adjugate over determinant).
// Uses dsmi_pkg for widths, cofactor tables and saturation.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_tvalid/req_tready   | req_tdata: nine elements, Q16.16
//  rsp     | out       | rsp_tvalid/rsp_tready   | rsp_tdata: inverse, determinant, singular
//  csr     | in        | csr_valid/csr_ready     | csr_data: active dimension
//
// One item enters per cycle while the output is not stalled; each result passes
// through the 32 one-bit restoring stages of the per-entry dividers.
// Reset is synchronous and clears all valid bits and sets the dimension to 3.
// A stalled output freezes the whole pipeline; a one-entry skid register on the
// input keeps req_tready free of any combinational path from rsp_tready.
`default_nettype none

module dim_select_matrix_inverse_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // elem_xx, elem_xy, elem_xz, elem_yx, elem_yy, elem_yz, elem_zx, elem_zy, elem_zz
   input  wire logic [dsmi_pkg::IN_TDATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // inv_xx .. inv_zz, determinant, singular, seven zero pad bits
   output logic [dsmi_pkg::OUT_TDATA_W-1:0]       rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [1:0]                        csr_data
);

   localparam int N    = dsmi_pkg::N;
   localparam int EW   = dsmi_pkg::EW;
   localparam int PW   = dsmi_pkg::PW;
   localparam int CW   = dsmi_pkg::CW;
   localparam int DETW = dsmi_pkg::DETW;
   localparam int MAGW = dsmi_pkg::MAGW;
   localparam int AMW  = dsmi_pkg::AMW;
   localparam int QW   = dsmi_pkg::QW;
   localparam int FS   = 7;   // stages ahead of the dividers

   logic [1:0] dim_ff;
   logic       en;
   logic       accept;
   logic       skid_v_ff;
   logic [dsmi_pkg::IN_TDATA_W-1:0] skid_data_ff;
   logic [dsmi_pkg::IN_TDATA_W-1:0] src_data;
   logic       src_valid;
   logic [1:0] k_in;

   logic [FS-1:0] fv_ff;
   logic [QW:0]   dv_ff;
   logic          rv_ff;
   logic          out_v_ff;

   logic [1:0]   k_ff   [FS];
   logic [N-1:0] act_ff [FS];

   dsmi_pkg::elem_type e_in  [N];
   logic [N-1:0]       act_in;
   dsmi_pkg::elem_type e0_ff [N];
   dsmi_pkg::elem_type r1_ff [3];
   dsmi_pkg::elem_type r2_ff [3];

   logic signed [PW-1:0]   pa_ff   [N];
   logic signed [PW-1:0]   pb_ff   [N];
   logic signed [CW-1:0]   adj2_ff [N];
   logic signed [CW-1:0]   adj3_ff [N];
   logic signed [CW-1:0]   adj4_ff [N];
   logic signed [CW-1:0]   adj5_ff [N];
   logic signed [CW-1:0]   pl_ff   [3];
   logic signed [CW-1:0]   ph_ff   [3];
   logic signed [DETW-1:0] t_ff    [3];
   logic signed [DETW-1:0] det_ff;

   logic [MAGW-1:0] dmag_ff;
   logic            dneg_ff;
   logic            dzero_ff;
   logic [AMW-1:0]  amag_ff [N];
   logic [N-1:0]    aneg_ff;
   logic [N-1:0]    azero_ff;

   dsmi_pkg::side_type side_in;
   logic [MAGW-1:0]    rem0_in [N];
   logic [MAGW:0]      dsum16;
   logic [MAGW:0]      dsum32;
   logic [MAGW-1:0]    det_m;
   dsmi_pkg::sat_type  det_sat;

   dsmi_pkg::side_type side_ff [QW+1];
   logic [MAGW-1:0]    rem_ff  [QW+1][N];
   logic [QW-1:0]      quo_ff  [QW+1][N];
   logic [MAGW-1:0]    rem_in  [QW][N];
   logic               qbit_in [QW][N];

   dsmi_pkg::side_type side_r_ff;
   logic [QW:0]        qr_ff [N];
   logic [QW:0]        qr_in [N];

   logic [EW-1:0] inv_in [N];
   logic [N-1:0]  flag_in;
   logic [EW-1:0] inv_ff [N];
   logic [EW-1:0] det_out_ff;
   logic          sing_ff;

   // Control: the whole pipeline advances whenever the output register can move.
   assign en         = !out_v_ff || rsp_tready;
   assign req_tready = !skid_v_ff && !reset;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = !reset;
   assign src_valid  = skid_v_ff || accept;
   assign src_data   = skid_v_ff ? skid_data_ff : req_tdata;
   assign k_in       = (dim_ff == dsmi_pkg::DIM_NONE) ? dsmi_pkg::DIM_FULL : dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= dsmi_pkg::DIM_FULL;
      end else if (csr_valid && csr_ready) begin
         dim_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (en) begin
         skid_v_ff <= 1'b0;
      end else if (accept) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && accept) begin
         skid_data_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff    <= '0;
         dv_ff    <= '0;
         rv_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         fv_ff    <= {fv_ff[FS-2:0], src_valid};
         dv_ff    <= {dv_ff[QW-1:0], fv_ff[FS-1]};
         rv_ff    <= dv_ff[QW];
         out_v_ff <= rv_ff;
      end
   end

   // Elements outside the active block are replaced by the identity, so the
   // full 3x3 adjugate and determinant give the smaller block's results.
   for (genvar i = 0; i < N; i++) begin : g_entry
      localparam int R = i / 3;
      localparam int C = i % 3;
      assign act_in[i] = (2'(R) < k_in) && (2'(C) < k_in);
      assign e_in[i]   = act_in[i] ? src_data[i*EW +: EW] :
                         ((R == C) ? EW'(1) : EW'(0));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff     <= e_in;
         k_ff[0]   <= k_in;
         act_ff[0] <= act_in;
         for (int s = 1; s < FS; s++) begin
            k_ff[s]   <= k_ff[s-1];
            act_ff[s] <= act_ff[s-1];
         end
      end
   end

   // Stage 1 and 2: cofactor products, then differences.
   for (genvar i = 0; i < N; i++) begin : g_cof
      always_ff @(posedge clock) begin
         if (en) begin
            pa_ff[i]   <= e0_ff[dsmi_pkg::COF_A[i]] * e0_ff[dsmi_pkg::COF_B[i]];
            pb_ff[i]   <= e0_ff[dsmi_pkg::COF_C[i]] * e0_ff[dsmi_pkg::COF_D[i]];
            adj2_ff[i] <= CW'(pa_ff[i]) - CW'(pb_ff[i]);
            adj3_ff[i] <= adj2_ff[i];
            adj4_ff[i] <= adj3_ff[i];
            adj5_ff[i] <= adj4_ff[i];
         end
      end
   end

   // Stages 3 to 5: first-row expansion, each 32x65 product split in two halves.
   for (genvar j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clock) begin
         if (en) begin
            r1_ff[j] <= e0_ff[j];
            r2_ff[j] <= r1_ff[j];
            pl_ff[j] <= r2_ff[j] * $signed({1'b0, adj2_ff[3*j][EW-1:0]});
            ph_ff[j] <= r2_ff[j] * $signed(adj2_ff[3*j][CW-1:EW]);
            t_ff[j]  <= (DETW'(ph_ff[j]) <<< EW) + DETW'(pl_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff   <= t_ff[0] + t_ff[1] + t_ff[2];
         dneg_ff  <= det_ff[DETW-1];
         dzero_ff <= (det_ff == '0);
         dmag_ff  <= det_ff[DETW-1] ? MAGW'(-det_ff) : MAGW'(det_ff);
         for (int i = 0; i < N; i++) begin
            aneg_ff[i]  <= adj5_ff[i][CW-1];
            azero_ff[i] <= (adj5_ff[i] == '0);
            amag_ff[i]  <= adj5_ff[i][CW-1] ? AMW'(-adj5_ff[i]) : AMW'(adj5_ff[i]);
         end
      end
   end

   // Stage 7: overflow screen, divider start and the rounded determinant.
   always_comb begin
      dsum16 = {1'b0, dmag_ff} + (MAGW+1)'(32'h0000_8000);
      dsum32 = {1'b0, dmag_ff} + (MAGW+1)'(32'h8000_0000);
      case (k_ff[FS-1])
         dsmi_pkg::DIM_ONE: det_m = dmag_ff;
         dsmi_pkg::DIM_TWO: det_m = MAGW'(dsum16[MAGW:16]);
         default:           det_m = MAGW'(dsum32[MAGW:32]);
      endcase
      det_sat = dsmi_pkg::sat32(det_m, dneg_ff);

      side_in.dmag  = dmag_ff;
      side_in.dzero = dzero_ff;
      side_in.act   = act_ff[FS-1];
      side_in.azero = azero_ff;
      side_in.neg   = aneg_ff ^ {N{dneg_ff}};
      for (int i = 0; i < N; i++) begin
         // A quotient of 2^32 or more is certain once the cofactor reaches the determinant.
         side_in.big[i] = MAGW'(amag_ff[i]) >= dmag_ff;
         rem0_in[i]     = side_in.big[i] ? '0 : MAGW'(amag_ff[i]);
      end
      if (dzero_ff) begin
         side_in.det_out  = '0;
         side_in.det_flag = 1'b1;
      end else begin
         side_in.det_out  = det_sat.value;
         side_in.det_flag = det_sat.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         rem_ff[0]  <= rem0_in;
         for (int i = 0; i < N; i++) begin
            quo_ff[0][i] <= '0;
         end
      end
   end

   // Restoring division, one quotient bit per stage in each of the nine lanes.
   for (genvar s = 0; s < QW; s++) begin : g_div
      for (genvar i = 0; i < N; i++) begin : g_lane
         logic [MAGW:0] shl;
         logic [MAGW:0] diff;
         assign shl           = {rem_ff[s][i], 1'b0};
         assign diff          = shl - {1'b0, side_ff[s].dmag};
         assign qbit_in[s][i] = shl >= {1'b0, side_ff[s].dmag};
         assign rem_in[s][i]  = qbit_in[s][i] ? diff[MAGW-1:0] : shl[MAGW-1:0];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s+1] <= side_ff[s];
            for (int i = 0; i < N; i++) begin
               rem_ff[s+1][i] <= rem_in[s][i];
               quo_ff[s+1][i] <= {quo_ff[s][i][QW-2:0], qbit_in[s][i]};
            end
         end
      end
   end

   // Round to nearest, ties away from zero, on the magnitude.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         qr_in[i] = {1'b0, quo_ff[QW][i]} +
                    (QW+1)'({rem_ff[QW][i], 1'b0} >= {1'b0, side_ff[QW].dmag});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_r_ff <= side_ff[QW];
         qr_ff     <= qr_in;
      end
   end

   always_comb begin
      dsmi_pkg::sat_type q_sat;
      for (int i = 0; i < N; i++) begin
         q_sat = dsmi_pkg::sat32(MAGW'(qr_ff[i]), side_r_ff.neg[i]);
         if (!side_r_ff.act[i]) begin
            inv_in[i]  = '0;
            flag_in[i] = 1'b0;
         end else if (side_r_ff.dzero) begin
            inv_in[i]  = side_r_ff.azero[i] ? EW'(0) :
                         (side_r_ff.neg[i] ? dsmi_pkg::SAT_NEG : dsmi_pkg::SAT_POS);
            flag_in[i] = 1'b1;
         end else if (side_r_ff.big[i]) begin
            inv_in[i]  = side_r_ff.neg[i] ? dsmi_pkg::SAT_NEG : dsmi_pkg::SAT_POS;
            flag_in[i] = 1'b1;
         end else begin
            inv_in[i]  = q_sat.value;
            flag_in[i] = q_sat.sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff     <= inv_in;
         det_out_ff <= side_r_ff.det_out;
         sing_ff    <= side_r_ff.det_flag || (|flag_in);
      end
   end

   assign rsp_tvalid = out_v_ff;
   for (genvar i = 0; i < N; i++) begin : g_pack
      assign rsp_tdata[i*EW +: EW] = inv_ff[i];
   end
   assign rsp_tdata[dsmi_pkg::DET_LSB +: EW] = det_out_ff;
   assign rsp_tdata[dsmi_pkg::SING_BIT]      = sing_ff;
   assign rsp_tdata[dsmi_pkg::OUT_TDATA_W-1:dsmi_pkg::SING_BIT+1] = '0;

endmodule

`default_nettype wire

### design/dsmi_check.sv
// Port-level checks for the matrix inverse core, attached by the bind below.
// Uses dsmi_pkg for the result layout.
`default_nettype none

module dsmi_check (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [dsmi_pkg::IN_TDATA_W-1:0]   req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [dsmi_pkg::OUT_TDATA_W-1:0]  rsp_tdata,
   input wire logic                              csr_valid,
   input wire logic                              csr_ready,
   input wire logic [1:0]                        csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_tready)
      else $error("input not ready after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
      rsp_tdata[dsmi_pkg::OUT_TDATA_W-1:dsmi_pkg::SING_BIT+1] == '0)
      else $error("pad bits of rsp_tdata not zero");

endmodule

bind dim_select_matrix_inverse_core dsmi_check u_dsmi_check (.*);

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for dim_select_matrix_inverse_core: directed table rows carry
// typed-in results or, like random tensors, use a bit-exact adjugate-over-determinant predictor.
// Depends on dsmi_pkg and the core RTL.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N           = dsmi_pkg::N;
   localparam int EW          = dsmi_pkg::EW;
   localparam int IN_TDATA_W  = dsmi_pkg::IN_TDATA_W;
   localparam int OUT_TDATA_W = dsmi_pkg::OUT_TDATA_W;
   localparam int DET_LSB     = dsmi_pkg::DET_LSB;
   localparam int SING_BIT    = dsmi_pkg::SING_BIT;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int RANDOM_ITEMS   = 400;

   typedef struct packed {
      logic [N-1:0][EW-1:0] inv;
      logic [EW-1:0]        det;
      logic                 sing;
   } inverse_result;

   typedef struct {
      logic          typed;
      inverse_result value;
   } sent_info;

   typedef struct {
      logic [1:0]              dim;
      logic [IN_TDATA_W-1:0]   data;
      logic                    typed;
      inverse_result           value;
   } table_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_data = dsmi_pkg::DIM_FULL;

   inverse_result expected_inverses[$];
   sent_info      sent_items[$];
   table_row      rows[$];
   logic [1:0]    model_dim;
   int            errors = 0;
   int            idle_cycles = 0;
   int            stall_left = 0;
   int            run_left = 0;

   dim_select_matrix_inverse_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Returns {saturated, value} for a magnitude and sign.
   function automatic logic [EW:0] saturate(input logic [127:0] mag, input logic neg);
      if (neg) begin
         if (mag > 128'h8000_0000) return {1'b1, dsmi_pkg::SAT_NEG};
         return {1'b0, EW'(128'd0 - mag)};
      end
      if (mag > 128'h7FFF_FFFF) return {1'b1, dsmi_pkg::SAT_POS};
      return {1'b0, mag[EW-1:0]};
   endfunction

   function automatic inverse_result predict_inverse(input logic [IN_TDATA_W-1:0] d,
                                                     input logic [1:0] dim);
      logic signed [127:0] e[N];
      logic signed [127:0] adj[N];
      logic signed [127:0] det;
      logic [127:0] dmag, num, q, r, m;
      logic [EW:0] s;
      int k;
      inverse_result res;
      k = (dim == dsmi_pkg::DIM_NONE) ? 3 : int'(dim);
      for (int i = 0; i < N; i++) begin
         e[i] = $signed(d[EW*i +: EW]);
         adj[i] = '0;
      end
      if (k == 1) begin
         adj[0] = 1;
         det = e[0];
      end else if (k == 2) begin
         adj[0] = e[4];
         adj[1] = -e[1];
         adj[3] = -e[3];
         adj[4] = e[0];
         det = e[0] * e[4] - e[1] * e[3];
      end else begin
         adj[0] = e[4] * e[8] - e[7] * e[5];
         adj[1] = e[2] * e[7] - e[8] * e[1];
         adj[2] = e[1] * e[5] - e[4] * e[2];
         adj[3] = e[5] * e[6] - e[8] * e[3];
         adj[4] = e[0] * e[8] - e[6] * e[2];
         adj[5] = e[2] * e[3] - e[5] * e[0];
         adj[6] = e[3] * e[7] - e[6] * e[4];
         // Corrected ZY cofactor: XY*ZX - XX*ZY.
         adj[7] = e[1] * e[6] - e[7] * e[0];
         adj[8] = e[0] * e[4] - e[3] * e[1];
         det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
      end
      res = '0;
      dmag = (det < 0) ? -det : det;
      for (int i = 0; i < N; i++) begin
         if (i / 3 < k && i % 3 < k) begin
            if (det == 0) begin
               res.sing = 1'b1;
               if (adj[i] != 0)
                  res.inv[i] = (adj[i] < 0) ? dsmi_pkg::SAT_NEG : dsmi_pkg::SAT_POS;
            end else begin
               num = ((adj[i] < 0) ? -adj[i] : adj[i]) << 32;
               q = num / dmag;
               r = num % dmag;
               if ((r << 1) >= dmag) q = q + 1;
               s = saturate(q, (adj[i] < 0) != (det < 0));
               res.inv[i] = s[EW-1:0];
               if (s[EW]) res.sing = 1'b1;
            end
         end
      end
      if (det == 0) begin
         res.sing = 1'b1;
      end else begin
         m = dmag;
         if (k > 1) m = (m + (128'd1 << (16 * (k - 1) - 1))) >> (16 * (k - 1));
         s = saturate(m, det < 0);
         res.det = s[EW-1:0];
         if (s[EW]) res.sing = 1'b1;
      end
      return res;
   endfunction

   function automatic logic [IN_TDATA_W-1:0] pack_tensor(
         input logic [EW-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz);
      return {zz, zy, zx, yz, yy, yx, xz, xy, xx};
   endfunction

   // Result with the same value on every active diagonal entry, zero elsewhere.
   function automatic inverse_result diagonal_result(input logic [1:0] dim,
         input logic [EW-1:0] diag, input logic [EW-1:0] det, input logic sing);
      inverse_result res;
      int k;
      k = (dim == dsmi_pkg::DIM_NONE) ? 3 : int'(dim);
      res = '0;
      for (int i = 0; i < k; i++) res.inv[4 * i] = diag;
      res.det = det;
      res.sing = sing;
      return res;
   endfunction

   function automatic logic [EW-1:0] random_element(input int style);
      logic [EW-1:0] mag;
      case (style)
         0: return $urandom;
         1: begin
            mag = $urandom_range(0, 32'h0004_0000);
            return $urandom_range(0, 1) ? -mag : mag;
         end
         default: begin
            case ($urandom_range(0, 6))
               0: return dsmi_pkg::SAT_POS;
               1: return dsmi_pkg::SAT_NEG;
               2: return '0;
               3: return 32'h0001_0000;
               4: return 32'hFFFF_0000;
               5: return 32'd1;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void add_row(input logic [1:0] dim, input logic [IN_TDATA_W-1:0] data,
                                   input logic typed, input inverse_result value);
      table_row row;
      row.dim = dim;
      row.data = data;
      row.typed = typed;
      row.value = value;
      rows.push_back(row);
   endfunction

   // Monitor: records accepted items, predicts and checks results.
   always @(posedge clock) begin
      inverse_result got, want;
      sent_info info;
      if (reset) begin
         model_dim = dsmi_pkg::DIM_FULL;
      end else begin
         if (csr_valid && csr_ready) model_dim = csr_data;
         if (req_tvalid && req_tready) begin
            info = sent_items.pop_front();
            expected_inverses.push_back(info.typed ? info.value
                                                   : predict_inverse(req_tdata, model_dim));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.inv = rsp_tdata[N*EW-1:0];
            got.det = rsp_tdata[DET_LSB +: EW];
            got.sing = rsp_tdata[SING_BIT];
            if (expected_inverses.size() == 0) begin
               $display("%0t: result with none expected: %h", $realtime, rsp_tdata);
               errors++;
            end else begin
               want = expected_inverses.pop_front();
               for (int i = 0; i < N; i++)
                  if (got.inv[i] !== want.inv[i]) begin
                     $display("%0t: inv[%0d] expected %h actual %h", $realtime, i,
                              want.inv[i], got.inv[i]);
                     errors++;
                  end
               if (got.det !== want.det) begin
                  $display("%0t: determinant expected %h actual %h", $realtime,
                           want.det, got.det);
                  errors++;
               end
               if (got.sing !== want.sing) begin
                  $display("%0t: singular expected %b actual %b", $realtime,
                           want.sing, got.sing);
                  errors++;
               end
            end
         end
      end
   end

   // Output back-pressure: runs of ready, mostly short stalls, a few long ones.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (run_left > 0) begin
         run_left--;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                 : $urandom_range(20, 60);
         rsp_tready <= 1'b0;
      end else begin
         run_left = $urandom_range(0, 40);
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("dim_select_matrix_inverse_core regression: fail");
         $finish;
      end
   end

   task automatic send_tensor(input logic [IN_TDATA_W-1:0] data, input logic typed,
                              input inverse_result value, input int gap);
      sent_info info;
      info.typed = typed;
      info.value = value;
      sent_items.push_back(info);
      req_tvalid <= 1'b1;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The sender stops offering before it waits, so no item is taken twice.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_inverses.size() != 0 || sent_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_dimension(input logic [1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [1:0] dim_now;
      logic [1:0] phase_dims[5];
      logic [EW-1:0] el[N];
      int style, item_style;
      logic no_gaps;
      inverse_result none;

      none = '0;
      phase_dims = '{dsmi_pkg::DIM_FULL, dsmi_pkg::DIM_ONE, dsmi_pkg::DIM_TWO,
                     dsmi_pkg::DIM_NONE, dsmi_pkg::DIM_FULL};
      add_row(dsmi_pkg::DIM_FULL,
              pack_tensor(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000),
              1, diagonal_result(dsmi_pkg::DIM_FULL, 32'h10000, 32'h10000, 0));
      add_row(dsmi_pkg::DIM_FULL, '0, 1, diagonal_result(dsmi_pkg::DIM_FULL, 0, 0, 1));
      add_row(dsmi_pkg::DIM_FULL, {N{dsmi_pkg::SAT_POS}}, 1,
              diagonal_result(dsmi_pkg::DIM_FULL, 0, 0, 1));
      add_row(dsmi_pkg::DIM_FULL, {N{dsmi_pkg::SAT_NEG}}, 1,
              diagonal_result(dsmi_pkg::DIM_FULL, 0, 0, 1));
      add_row(dsmi_pkg::DIM_FULL,
              pack_tensor(32'h20000, 0, 0, 0, 32'h20000, 0, 0, 0, 32'h20000),
              1, diagonal_result(dsmi_pkg::DIM_FULL, 32'h8000, 32'h80000, 0));
      add_row(dsmi_pkg::DIM_FULL,
              pack_tensor(dsmi_pkg::SAT_POS, 0, 0, 0, dsmi_pkg::SAT_POS, 0, 0, 0,
                          dsmi_pkg::SAT_POS), 0, none);
      add_row(dsmi_pkg::DIM_FULL,
              pack_tensor(dsmi_pkg::SAT_NEG, 0, 0, 0, dsmi_pkg::SAT_NEG, 0, 0, 0,
                          dsmi_pkg::SAT_NEG), 0, none);
      add_row(dsmi_pkg::DIM_FULL, pack_tensor(1, 0, 0, 0, 1, 0, 0, 0, 1), 0, none);
      add_row(dsmi_pkg::DIM_FULL,
              pack_tensor(32'h10000, 32'h20000, 32'h30000, 32'h5000, 32'hFFFE0000,
                          32'h7000, 32'h40000, 32'hFFF90000, 32'h18000), 0, none);
      add_row(dsmi_pkg::DIM_ONE, {{8{dsmi_pkg::SAT_POS}}, 32'h10000}, 1,
              diagonal_result(dsmi_pkg::DIM_ONE, 32'h10000, 32'h10000, 0));
      add_row(dsmi_pkg::DIM_ONE, {{8{32'hFFFF_FFFF}}, 32'd0}, 1,
              diagonal_result(dsmi_pkg::DIM_ONE, dsmi_pkg::SAT_POS, 0, 1));
      add_row(dsmi_pkg::DIM_ONE, {{8{32'h1234}}, 32'hFFFF0000}, 1,
              diagonal_result(dsmi_pkg::DIM_ONE, 32'hFFFF0000, 32'hFFFF0000, 0));
      add_row(dsmi_pkg::DIM_ONE, {{8{32'd0}}, 32'd1}, 0, none);
      add_row(dsmi_pkg::DIM_ONE, {{8{32'd0}}, dsmi_pkg::SAT_NEG}, 0, none);
      add_row(dsmi_pkg::DIM_TWO,
              pack_tensor(32'h10000, 0, dsmi_pkg::SAT_NEG, 0, 32'h10000, dsmi_pkg::SAT_POS,
                          '1, 5, 9),
              1, diagonal_result(dsmi_pkg::DIM_TWO, 32'h10000, 32'h10000, 0));
      add_row(dsmi_pkg::DIM_TWO, pack_tensor(0, 0, 7, 0, 0, 7, 7, 7, 7), 1,
              diagonal_result(dsmi_pkg::DIM_TWO, 0, 0, 1));
      add_row(dsmi_pkg::DIM_TWO,
              pack_tensor(dsmi_pkg::SAT_POS, dsmi_pkg::SAT_NEG, 0, dsmi_pkg::SAT_NEG,
                          dsmi_pkg::SAT_NEG, 0, 0, 0, 0), 0, none);
      add_row(dsmi_pkg::DIM_NONE,
              pack_tensor(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000),
              1, diagonal_result(dsmi_pkg::DIM_NONE, 32'h10000, 32'h10000, 0));
      add_row(dsmi_pkg::DIM_NONE,
              pack_tensor(dsmi_pkg::SAT_NEG, 1, 0, 0, dsmi_pkg::SAT_NEG, 1, 1, 0,
                          dsmi_pkg::SAT_NEG), 0, none);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      dim_now = dsmi_pkg::DIM_FULL;

      foreach (rows[i]) begin
         if (rows[i].dim != dim_now) begin
            write_dimension(rows[i].dim);
            dim_now = rows[i].dim;
         end
         send_tensor(rows[i].data, rows[i].typed, rows[i].value, pick_gap());
      end

      // Each phase change drains the core, so the sender also waits out every result.
      for (int p = 0; p < 5; p++) begin
         write_dimension(phase_dims[p]);
         no_gaps = (p == 2);
         for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
            item_style = $urandom_range(0, 19);
            for (int i = 0; i < N; i++) begin
               if (item_style < 10) style = 1;
               else if (item_style < 14) style = 0;
               else if (item_style < 17) style = $urandom_range(0, 2);
               else style = 1;
               el[i] = random_element(style);
            end
            // Repeated rows make a singular tensor with otherwise random content.
            if (item_style >= 17) begin
               el[3] = el[0];
               el[4] = el[1];
               el[5] = el[2];
            end
            send_tensor(pack_tensor(el[0], el[1], el[2], el[3], el[4], el[5], el[6], el[7],
                                    el[8]), 0, none, no_gaps ? 0 : pick_gap());
         end
      end

      req_tvalid <= 1'b0;
      drain();
      if (errors == 0 && expected_inverses.size() == 0)
         $display("dim_select_matrix_inverse_core regression: pass");
      else
         $display("dim_select_matrix_inverse_core regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
design/dsmi_pkg.sv
design/dim_select_matrix_inverse_core.sv
design/dsmi_check.sv
dv/testbench.sv
